>>> sv/json_string_escape_utf8_sanitize_core_macros.svh
// Assertion macros for the JSON string escaper checker.
// Expects clk and arst_n in the scope of each use.
`ifndef JSON_STRING_ESCAPE_UTF8_SANITIZE_CORE_MACROS_SVH
`define JSON_STRING_ESCAPE_UTF8_SANITIZE_CORE_MACROS_SVH

// same-edge implication
`define JSES_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("jses: same-cycle check failed");

// next-edge implication
`define JSES_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("jses: next-cycle check failed");

`endif

>>> sv/jses_pkg.sv
// Shared types and byte codes for the JSON string escaper.
// No dependencies; used by the front, queue, back and top level.
package jses_pkg;

	localparam int QUEUE_DEPTH_DEF = 2;

	localparam logic [7:0] CH_QUOTE = 8'h22;
	localparam logic [7:0] CH_BSLASH = 8'h5C;
	localparam logic [7:0] CH_LF = 8'h0A;
	localparam logic [7:0] CH_CR = 8'h0D;
	localparam logic [7:0] CH_TAB = 8'h09;
	localparam logic [7:0] CH_N = 8'h6E;
	localparam logic [7:0] CH_R = 8'h72;
	localparam logic [7:0] CH_T = 8'h74;
	localparam logic [7:0] CH_U = 8'h75;
	localparam logic [7:0] CH_ZERO = 8'h30;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_ASCII_END = 8'h80;

	localparam logic [7:0] REPL_B0 = 8'hEF;
	localparam logic [7:0] REPL_B1 = 8'hBF;
	localparam logic [7:0] REPL_B2 = 8'hBD;

	localparam logic [7:0] LEAD2_MIN = 8'hC2;
	localparam logic [7:0] LEAD2_MAX = 8'hDF;
	localparam logic [7:0] LEAD3_E0 = 8'hE0;
	localparam logic [7:0] LEAD3_ED = 8'hED;
	localparam logic [7:0] LEAD3_MAX = 8'hEF;
	localparam logic [7:0] LEAD4_F0 = 8'hF0;
	localparam logic [7:0] LEAD4_F4 = 8'hF4;
	localparam logic [7:0] CONT_MIN = 8'h80;
	localparam logic [7:0] CONT_MAX = 8'hBF;
	localparam logic [7:0] E0_LO = 8'hA0;
	localparam logic [7:0] ED_HI = 8'h9F;
	localparam logic [7:0] F0_LO = 8'h90;
	localparam logic [7:0] F4_HI = 8'h8F;

	typedef enum logic [1:0] {
		BK_NONE,
		BK_RAW,
		BK_ESC,
		BK_UHEX
	} jses_body_t;

	// one queued item: everything the back end emits for one input byte
	typedef struct packed {
		logic             open;
		logic [2:0]       pre;
		jses_body_t       kind;
		logic [2:0]       body_len;
		logic [3:0][7:0]  raw;
		logic [1:0]       post;
		logic             close;
	} jses_desc_t;

	typedef enum logic [2:0] {
		PH_OPEN,
		PH_PRE,
		PH_BODY,
		PH_POST,
		PH_CLOSE,
		PH_DONE
	} jses_phase_t;

	typedef struct packed {
		logic [2:0] len;
		logic [7:0] lo;
		logic [7:0] hi;
	} jses_lead_t;

endpackage

>>> sv/jses_front.sv
// Front end: accepts input bytes, tracks pending UTF-8 sequences and
// classifies each byte into a queue item. Depends on jses_pkg.
module jses_front (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	input  logic [7:0]           in_byte,
	input  logic                 is_last,
	input  logic                 q_full,
	output logic                 in_stall,
	output logic                 push,
	output jses_pkg::jses_desc_t desc
);
	import jses_pkg::*;

	logic            open_q;
	logic [7:0]      lead_q;
	logic [1:0][7:0] tail_q;
	logic [1:0]      hcnt_q;
	logic [2:0]      need_q;

	logic            n_open;
	logic [7:0]      n_lead;
	logic [1:0][7:0] n_tail;
	logic [1:0]      n_hcnt;
	logic [2:0]      n_need;
	logic [1:0]      eff_hcnt;
	logic [2:0]      eff_need;
	logic [7:0]      lo;
	logic [7:0]      hi;
	logic            do_lead;
	logic            accept;
	jses_lead_t      li_held;
	jses_lead_t      li_new;
	jses_desc_t      d;

	function automatic jses_lead_t lead_info(logic [7:0] b);
		jses_lead_t r;
		r.len = 3'd0;
		r.lo = CONT_MIN;
		r.hi = CONT_MAX;
		if (b >= LEAD2_MIN && b <= LEAD2_MAX) begin
			r.len = 3'd2;
		end else if (b == LEAD3_E0) begin
			r.len = 3'd3;
			r.lo = E0_LO;
		end else if (b > LEAD3_E0 && b <= LEAD3_MAX) begin
			r.len = 3'd3;
			if (b == LEAD3_ED)
				r.hi = ED_HI;
		end else if (b == LEAD4_F0) begin
			r.len = 3'd4;
			r.lo = F0_LO;
		end else if (b > LEAD4_F0 && b <= LEAD4_F4) begin
			r.len = 3'd4;
			if (b == LEAD4_F4)
				r.hi = F4_HI;
		end
		return r;
	endfunction

	assign li_held = lead_info(lead_q);
	assign li_new = lead_info(in_byte);
	assign accept = in_valid && !q_full;
	assign in_stall = q_full;

	always_comb begin
		d = '0;
		d.kind = BK_NONE;
		d.open = !open_q;
		eff_hcnt = open_q ? hcnt_q : 2'd0;
		eff_need = open_q ? need_q : 3'd0;
		n_lead = lead_q;
		n_tail = tail_q;
		n_hcnt = eff_hcnt;
		n_need = eff_need;
		do_lead = 1'b1;
		lo = li_held.lo;
		hi = li_held.hi;
		if (eff_hcnt != 2'd0) begin
			lo = CONT_MIN;
			hi = CONT_MAX;
		end
		if (eff_need != 3'd0) begin
			if (in_byte >= lo && in_byte <= hi) begin
				do_lead = 1'b0;
				if ({1'b0, eff_hcnt} + 3'd2 >= eff_need) begin
					d.kind = BK_RAW;
					d.body_len = {1'b0, eff_hcnt} + 3'd2;
					d.raw[0] = lead_q;
					d.raw[1] = (eff_hcnt == 2'd0) ? in_byte : tail_q[0];
					d.raw[2] = (eff_hcnt == 2'd1) ? in_byte : tail_q[1];
					d.raw[3] = in_byte;
					n_hcnt = 2'd0;
					n_need = 3'd0;
				end else begin
					n_tail[eff_hcnt[0]] = in_byte;
					n_hcnt = eff_hcnt + 2'd1;
				end
			end else begin
				// held lead and tails each give a replacement char
				d.pre = {1'b0, eff_hcnt} + 3'd1;
				n_hcnt = 2'd0;
				n_need = 3'd0;
			end
		end
		if (do_lead) begin
			case (in_byte)
				CH_QUOTE, CH_BSLASH: begin
					d.kind = BK_ESC;
					d.body_len = 3'd2;
					d.raw[0] = in_byte;
				end
				CH_LF: begin
					d.kind = BK_ESC;
					d.body_len = 3'd2;
					d.raw[0] = CH_N;
				end
				CH_CR: begin
					d.kind = BK_ESC;
					d.body_len = 3'd2;
					d.raw[0] = CH_R;
				end
				CH_TAB: begin
					d.kind = BK_ESC;
					d.body_len = 3'd2;
					d.raw[0] = CH_T;
				end
				default: begin
					if (in_byte < CH_SPACE) begin
						d.kind = BK_UHEX;
						d.body_len = 3'd6;
						d.raw[0] = in_byte;
					end else if (in_byte < CH_ASCII_END) begin
						d.kind = BK_RAW;
						d.body_len = 3'd1;
						d.raw[0] = in_byte;
					end else if (li_new.len != 3'd0) begin
						n_lead = in_byte;
						n_hcnt = 2'd0;
						n_need = li_new.len;
					end else begin
						d.pre = d.pre + 3'd1;
					end
				end
			endcase
		end
		if (is_last) begin
			if (n_need != 3'd0)
				d.post = n_hcnt + 2'd1;
			d.close = 1'b1;
			n_open = 1'b0;
			n_hcnt = 2'd0;
			n_need = 3'd0;
		end else begin
			n_open = 1'b1;
		end
	end

	assign desc = d;
	assign push = accept && (d.open || d.pre != 3'd0 || d.body_len != 3'd0 || d.close);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			open_q <= 1'b0;
			hcnt_q <= 2'd0;
			need_q <= 3'd0;
		end else if (accept) begin
			open_q <= n_open;
			hcnt_q <= n_hcnt;
			need_q <= n_need;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			lead_q <= n_lead;
			tail_q <= n_tail;
		end
	end

endmodule

>>> sv/jses_queue.sv
// Short item queue between front and back end.
// Depends on jses_pkg for the item type.
module jses_queue #(
	parameter int DEPTH = jses_pkg::QUEUE_DEPTH_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	input  jses_pkg::jses_desc_t wr_desc,
	input  logic                 pop,
	output logic                 full,
	output logic                 empty,
	output jses_pkg::jses_desc_t head
);
	import jses_pkg::*;

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
	localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

	jses_desc_t       mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] cnt_q;

	assign full = (cnt_q == FULL_CNT);
	assign empty = (cnt_q == '0);
	assign head = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_ptr_q] <= wr_desc;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q <= '0;
		end else begin
			if (push)
				wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + 1'b1;
			if (pop)
				rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + 1'b1;
			if (push && !pop)
				cnt_q <= cnt_q + 1'b1;
			else if (pop && !push)
				cnt_q <= cnt_q - 1'b1;
		end
	end

endmodule

>>> sv/jses_back.sv
// Back end: expands the queue head into output bytes, one per cycle while out_stall is low,
// through an output register. Depends on jses_pkg.
module jses_back (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 q_empty,
	input  jses_pkg::jses_desc_t head,
	output logic                 pop,
	input  logic                 out_stall,
	output logic                 out_valid,
	output logic [7:0]           out_byte,
	output logic                 run_end
);
	import jses_pkg::*;

	logic        started_q;
	jses_phase_t phase_q;
	logic [3:0]  idx_q;
	logic        n_started;
	jses_phase_t n_phase;
	logic [3:0]  n_idx;

	logic        out_valid_q;
	logic [7:0]  out_byte_q;
	logic        run_end_q;

	logic        advance;
	jses_phase_t cur_ph;
	jses_phase_t after_ph;
	logic [3:0]  cur_len;
	logic [7:0]  cur_byte;
	logic        idx_end;
	logic        last;

	function automatic logic [7:0] hex_digit(logic [3:0] v);
		return (v < 4'd10) ? CH_ZERO + {4'd0, v} : 8'h57 + {4'd0, v};
	endfunction

	// replacement char bytes repeat every three positions
	function automatic logic [7:0] repl_byte(logic [3:0] i);
		logic [7:0] r;
		case (i)
			4'd0, 4'd3, 4'd6, 4'd9:   r = REPL_B0;
			4'd1, 4'd4, 4'd7, 4'd10:  r = REPL_B1;
			default:                  r = REPL_B2;
		endcase
		return r;
	endfunction

	function automatic logic [3:0] ph_len(jses_desc_t d, jses_phase_t p);
		logic [3:0] r;
		case (p)
			PH_OPEN:  r = {3'd0, d.open};
			PH_PRE:   r = ({1'b0, d.pre} << 1) + {1'b0, d.pre};
			PH_BODY:  r = {1'b0, d.body_len};
			PH_POST:  r = ({2'd0, d.post} << 1) + {2'd0, d.post};
			PH_CLOSE: r = {3'd0, d.close};
			default:  r = 4'd0;
		endcase
		return r;
	endfunction

	// first phase at or after p that has bytes
	function automatic jses_phase_t next_ph(jses_desc_t d, jses_phase_t p);
		jses_phase_t r;
		r = PH_DONE;
		for (int i = 4; i >= 0; i--) begin
			if (ph_len(d, jses_phase_t'(3'(i))) != 4'd0 && 3'(i) >= p)
				r = jses_phase_t'(3'(i));
		end
		return r;
	endfunction

	function automatic logic [7:0] body_byte(jses_desc_t d, logic [3:0] i);
		logic [7:0] r;
		case (d.kind)
			BK_RAW: r = d.raw[i[1:0]];
			BK_ESC: r = (i == 4'd0) ? CH_BSLASH : d.raw[0];
			BK_UHEX: begin
				case (i)
					4'd0:    r = CH_BSLASH;
					4'd1:    r = CH_U;
					4'd4:    r = hex_digit(d.raw[0][7:4]);
					4'd5:    r = hex_digit(d.raw[0][3:0]);
					default: r = CH_ZERO;
				endcase
			end
			default: r = d.raw[0];
		endcase
		return r;
	endfunction

	assign advance = !q_empty && (!out_valid_q || !out_stall);
	assign cur_ph = started_q ? phase_q : next_ph(head, PH_OPEN);
	assign cur_len = ph_len(head, cur_ph);
	assign idx_end = (idx_q == cur_len - 4'd1);
	assign after_ph = next_ph(head, jses_phase_t'(cur_ph + 3'd1));
	assign last = idx_end && (after_ph == PH_DONE);
	assign pop = advance && last;

	always_comb begin
		case (cur_ph)
			PH_PRE, PH_POST: cur_byte = repl_byte(idx_q);
			PH_BODY:         cur_byte = body_byte(head, idx_q);
			default:         cur_byte = CH_QUOTE;
		endcase
	end

	always_comb begin
		n_started = started_q;
		n_phase = phase_q;
		n_idx = idx_q;
		if (advance) begin
			if (last) begin
				n_started = 1'b0;
				n_phase = PH_OPEN;
				n_idx = 4'd0;
			end else if (idx_end) begin
				n_started = 1'b1;
				n_phase = after_ph;
				n_idx = 4'd0;
			end else begin
				n_started = 1'b1;
				n_phase = cur_ph;
				n_idx = idx_q + 4'd1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			started_q <= 1'b0;
			phase_q <= PH_OPEN;
			idx_q <= 4'd0;
			out_valid_q <= 1'b0;
		end else begin
			started_q <= n_started;
			phase_q <= n_phase;
			idx_q <= n_idx;
			if (advance)
				out_valid_q <= 1'b1;
			else if (!out_stall)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_byte_q <= cur_byte;
			run_end_q <= last;
		end
	end

	assign out_valid = out_valid_q;
	assign out_byte = out_byte_q;
	assign run_end = run_end_q;

endmodule

>>> sv/json_string_escape_utf8_sanitize_core.sv
// The first output byte of an item passes through the item queue and output register.
// Throughput: one input byte per cycle while each gives one byte with out_stall low;
// a longer item (quotes, escapes, replacement chars) keeps the back end busy longer.
// The front stalls only when the item queue between front and back is full.
// Reset (arst_n low) clears string, sequence, queue and output state at once.
// Top level: front classifier, item queue and byte-expanding back end; needs jses_pkg.
module json_string_escape_utf8_sanitize_core #(
	parameter int QUEUE_DEPTH = jses_pkg::QUEUE_DEPTH_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] in_byte,
	input  logic       is_last,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [7:0] out_byte,
	output logic       run_end
);
	import jses_pkg::*;

	logic       push;
	logic       pop;
	logic       q_full;
	logic       q_empty;
	jses_desc_t wr_desc;
	jses_desc_t head;

	jses_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_byte  (in_byte),
		.is_last  (is_last),
		.q_full   (q_full),
		.in_stall (in_stall),
		.push     (push),
		.desc     (wr_desc)
	);

	jses_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.wr_desc (wr_desc),
		.pop     (pop),
		.full    (q_full),
		.empty   (q_empty),
		.head    (head)
	);

	jses_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_empty   (q_empty),
		.head      (head),
		.pop       (pop),
		.out_stall (out_stall),
		.out_valid (out_valid),
		.out_byte  (out_byte),
		.run_end   (run_end)
	);

endmodule

>>> sv/jses_checker.sv
// Port-level checker for the JSON string escaper, bound to the top level.
// Depends on the assertion macro header.
`include "json_string_escape_utf8_sanitize_core_macros.svh"

module jses_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       out_valid,
	input logic       out_stall,
	input logic [7:0] out_byte,
	input logic       run_end
);
	import jses_pkg::*;

	logic out_acc;
	logic bs_q;
	logic first_q;
	logic esc_ok;

	assign out_acc = out_valid && !out_stall;
	assign esc_ok = (out_byte == CH_QUOTE) || (out_byte == CH_BSLASH) || (out_byte == CH_N) ||
		(out_byte == CH_R) || (out_byte == CH_T) || (out_byte == CH_U);

	// bs_q: previous accepted output byte opened an escape (a second backslash closes it)
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bs_q <= 1'b0;
			first_q <= 1'b1;
		end else if (out_acc) begin
			bs_q <= (out_byte == CH_BSLASH) && !bs_q;
			first_q <= 1'b0;
		end
	end

	`JSES_ASSERT_NEXT(a_valid_held, out_valid && out_stall, out_valid)
	`JSES_ASSERT_NEXT(a_payload_held, out_valid && out_stall, $stable(out_byte) && $stable(run_end))
	`JSES_ASSERT_NOW(a_first_quote, out_acc && first_q, out_byte == CH_QUOTE)
	`JSES_ASSERT_NOW(a_escape_whole, out_acc && !bs_q && out_byte == CH_BSLASH, !run_end)
	`JSES_ASSERT_NOW(a_escape_char, out_acc && bs_q, esc_ok)

endmodule

bind json_string_escape_utf8_sanitize_core jses_checker u_jses_checker (.*);

>>> tb/json_literal_checker.sv
// Scoreboard for the JSON string escaper: predicts the literal bytes for every accepted
// input byte and compares them with the output channel in order.
// Depends on jses_pkg for the byte codes; instantiated next to the block by testbench.
module json_literal_checker (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	input  logic       in_stall,
	input  logic [7:0] in_byte,
	input  logic       is_last,
	input  logic       out_valid,
	input  logic       out_stall,
	input  logic [7:0] out_byte,
	input  logic       run_end,
	output int         errors,
	output int         pending,
	output int         strings_done,
	output int         bytes_in,
	output int         bytes_out,
	output int         repl_chars
);
	import jses_pkg::*;

	localparam logic [7:0] HEX_A = 8'h61;
	localparam int MAX_PER_ITEM = 16;

	typedef struct packed {
		logic       fin;
		logic [7:0] b;
	} lit_byte_t;

	lit_byte_t  literal_q[$];
	logic [7:0] item_bytes[$];

	// encoder state
	logic       str_open;
	logic [7:0] held_lead;
	logic [7:0] held_tail[2];
	logic [1:0] held_cnt;
	logic [2:0] need;

	int fail_cnt, n_str, n_in, n_out, n_repl;

	function automatic void put(input logic [7:0] b);
		if (item_bytes.size() < MAX_PER_ITEM)
			item_bytes.insert(item_bytes.size(), b);
	endfunction

	function automatic void put_repl();
		n_repl++;
		put(REPL_B0);
		put(REPL_B1);
		put(REPL_B2);
	endfunction

	function automatic logic [7:0] hex_digit(input logic [3:0] n);
		return (n < 10) ? 8'(CH_ZERO + n) : 8'(HEX_A + n - 10);
	endfunction

	// sequence length of a lead byte, and the allowed range of the byte after it
	function automatic int seq_len(input logic [7:0] b, output logic [7:0] lo,
			output logic [7:0] hi);
		lo = CONT_MIN;
		hi = CONT_MAX;
		if (b >= LEAD2_MIN && b <= LEAD2_MAX)
			return 2;
		if (b == LEAD3_E0) begin
			lo = E0_LO;
			return 3;
		end
		if (b == LEAD3_ED)
			hi = ED_HI;
		if (b > LEAD3_E0 && b <= LEAD3_MAX)
			return 3;
		if (b == LEAD4_F0) begin
			lo = F0_LO;
			return 4;
		end
		if (b == LEAD4_F4)
			hi = F4_HI;
		if (b > LEAD4_F0 && b <= LEAD4_F4)
			return 4;
		return 0;
	endfunction

	function automatic void encode_lead(input logic [7:0] b);
		logic [7:0] lo, hi;
		int len;
		case (b)
			CH_QUOTE: begin
				put(CH_BSLASH);
				put(CH_QUOTE);
			end
			CH_BSLASH: begin
				put(CH_BSLASH);
				put(CH_BSLASH);
			end
			CH_LF: begin
				put(CH_BSLASH);
				put(CH_N);
			end
			CH_CR: begin
				put(CH_BSLASH);
				put(CH_R);
			end
			CH_TAB: begin
				put(CH_BSLASH);
				put(CH_T);
			end
			default: begin
				if (b < CH_SPACE) begin
					put(CH_BSLASH);
					put(CH_U);
					put(CH_ZERO);
					put(CH_ZERO);
					put(hex_digit(b[7:4]));
					put(hex_digit(b[3:0]));
				end else if (b < CH_ASCII_END) begin
					put(b);
				end else begin
					len = seq_len(b, lo, hi);
					if (len == 0) begin
						put_repl();
					end else begin
						held_lead = b;
						held_cnt = 0;
						need = 3'(len);
					end
				end
			end
		endcase
	endfunction

	// held lead and every held continuation byte each become a replacement char
	function automatic void drop_held();
		int k;
		put_repl();
		for (k = 0; k < int'(held_cnt) && k < 2; k++)
			put_repl();
		held_cnt = 0;
		need = 0;
	endfunction

	function automatic void predict_item(input logic [7:0] b, input logic fin);
		logic [7:0] lo, hi;
		int j;
		lit_byte_t lb;
		item_bytes.delete();
		if (!str_open) begin
			put(CH_QUOTE);
			str_open = 1'b1;
			held_cnt = 0;
			need = 0;
		end
		if (need != 0) begin
			void'(seq_len(held_lead, lo, hi));
			if (held_cnt != 0) begin
				lo = CONT_MIN;
				hi = CONT_MAX;
			end
			if (b >= lo && b <= hi) begin
				if (int'(held_cnt) + 2 >= int'(need)) begin
					put(held_lead);
					for (j = 0; j < int'(held_cnt) && j < 2; j++)
						put(held_tail[j]);
					put(b);
					held_cnt = 0;
					need = 0;
				end else begin
					held_tail[held_cnt[0]] = b;
					held_cnt++;
				end
			end else begin
				drop_held();
				encode_lead(b);
			end
		end else begin
			encode_lead(b);
		end
		if (fin) begin
			if (need != 0)
				drop_held();
			put(CH_QUOTE);
			str_open = 1'b0;
			held_cnt = 0;
			need = 0;
		end
		for (j = 0; j < item_bytes.size(); j++) begin
			lb.fin = (j == item_bytes.size() - 1);
			lb.b = item_bytes[j];
			literal_q.insert(literal_q.size(), lb);
		end
	endfunction

	task automatic report(input string what, input int want, input int got);
		fail_cnt++;
		if (fail_cnt <= 10)
			$display("mismatch on output byte %0d: %s expected %02h got %02h",
				n_out, what, want, got);
	endtask

	always @(posedge clk or negedge arst_n) begin
		lit_byte_t want;
		if (!arst_n) begin
			literal_q.delete();
			str_open = 1'b0;
			held_cnt = 0;
			need = 0;
			fail_cnt = 0;
			n_str = 0;
			n_in = 0;
			n_out = 0;
			n_repl = 0;
		end else begin
			if (in_valid && !in_stall) begin
				n_in++;
				if (is_last)
					n_str++;
				predict_item(in_byte, is_last);
			end
			if (out_valid && !out_stall) begin
				if (literal_q.size() == 0) begin
					report("out_byte with nothing pending,", 0, out_byte);
				end else begin
					want = literal_q.pop_front();
					if (out_byte !== want.b)
						report("out_byte", want.b, out_byte);
					if (run_end !== want.fin)
						report("run_end", want.fin, run_end);
				end
				n_out++;
			end
		end
		errors <= fail_cnt;
		pending <= literal_q.size();
		strings_done <= n_str;
		bytes_in <= n_in;
		bytes_out <= n_out;
		repl_chars <= n_repl;
	end

endmodule

>>> tb/testbench.sv
// Top of the JSON string escaper bench: clock, reset, string stimulus and output stalls.
// Needs jses_pkg, json_string_escape_utf8_sanitize_core and json_literal_checker.
module testbench;
	import jses_pkg::*;

	localparam int CYCLE_LIMIT = 500000;
	localparam int RANDOM_ITEMS = 400;
	localparam int QUIET_FROM = 320;

	logic       clk;
	logic       arst_n;
	logic       in_valid;
	logic       in_stall;
	logic [7:0] in_byte;
	logic       is_last;
	logic       out_valid;
	logic       out_stall;
	logic [7:0] out_byte;
	logic       run_end;

	int errors, pending, strings_done, bytes_in, bytes_out, repl_chars;
	int cycles;
	int sent;
	logic calm, quiet;
	logic [7:0] text_q[$];

	json_string_escape_utf8_sanitize_core i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.in_byte  (in_byte),
		.is_last  (is_last),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_byte (out_byte),
		.run_end  (run_end)
	);

	json_literal_checker i_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.in_byte     (in_byte),
		.is_last     (is_last),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.out_byte    (out_byte),
		.run_end     (run_end),
		.errors      (errors),
		.pending     (pending),
		.strings_done(strings_done),
		.bytes_in    (bytes_in),
		.bytes_out   (bytes_out),
		.repl_chars  (repl_chars)
	);

	initial clk = 1'b0;
	always #1 clk = ~clk;

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("simulation failed");
			$finish;
		end
	end

	// receiver stalls in random bursts
	initial begin
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (!quiet && !calm && $urandom_range(0, 5) == 0) begin
				out_stall <= 1'b1;
				repeat ($urandom_range(1, 19)) @(posedge clk);
				out_stall <= 1'b0;
			end
		end
	end

	task automatic send_byte(input logic [7:0] b, input logic fin);
		if (!quiet && !calm && $urandom_range(0, 6) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 19)) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_byte <= b;
		is_last <= fin;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		sent++;
	endtask

	task automatic send_text();
		int i;
		for (i = 0; i < text_q.size(); i++)
			send_byte(text_q[i], i == text_q.size() - 1);
		text_q.delete();
	endtask

	// one character: mostly well-formed UTF-8, some escapes, noise and broken sequences
	task automatic add_char();
		logic [7:0] seq[4];
		logic [7:0] lo, hi;
		int n, k;
		n = 1;
		lo = CONT_MIN;
		hi = CONT_MAX;
		case ($urandom_range(0, 9))
			0, 1: seq[0] = 8'($urandom_range(8'h20, 8'h7E));
			2: begin
				if ($urandom_range(0, 2) == 0)
					seq[0] = $urandom_range(0, 1) ? CH_QUOTE : CH_BSLASH;
				else
					seq[0] = 8'($urandom_range(0, 8'h1F));
			end
			8: seq[0] = 8'($urandom_range(0, 255));
			default: begin
				n = $urandom_range(2, 4);
				case (n)
					2: seq[0] = 8'($urandom_range(LEAD2_MIN, LEAD2_MAX));
					3: seq[0] = 8'($urandom_range(LEAD3_E0, LEAD3_MAX));
					default: seq[0] = 8'($urandom_range(LEAD4_F0, LEAD4_F4));
				endcase
				if (seq[0] == LEAD3_E0)
					lo = E0_LO;
				if (seq[0] == LEAD3_ED)
					hi = ED_HI;
				if (seq[0] == LEAD4_F0)
					lo = F0_LO;
				if (seq[0] == LEAD4_F4)
					hi = F4_HI;
				seq[1] = 8'($urandom_range(lo, hi));
				for (k = 2; k < n; k++)
					seq[k] = 8'($urandom_range(CONT_MIN, CONT_MAX));
				// break some: cut short, or spoil a continuation byte
				if ($urandom_range(0, 4) == 0) begin
					if ($urandom_range(0, 1))
						n = $urandom_range(1, n - 1);
					else
						seq[$urandom_range(1, n - 1)] = 8'($urandom_range(0, 255));
				end
			end
		endcase
		for (k = 0; k < n; k++)
			text_q.insert(text_q.size(), seq[k]);
	endtask

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_byte = 8'h00;
		is_last = 1'b0;
		out_stall = 1'b0;
		cycles = 0;
		sent = 0;
		calm = 1'b0;
		quiet = 1'b0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// escapes, control bytes, extremes, a byte that cannot lead
		text_q = '{8'h00, 8'h22, 8'h5C, 8'h0A, 8'h0D, 8'h09, 8'h7F, 8'hFF};
		send_text();
		// boundary sequences, then a lead followed by plain ASCII
		text_q = '{8'hE0, 8'hA0, 8'h80, 8'hF4, 8'h8F, 8'hBF, 8'hBF, 8'hE1, 8'h41};
		send_text();
		text_q = '{8'hED, 8'h9F, 8'h80};
		send_text();
		// two held tails dropped, then a control byte and the close: longest output
		text_q = '{8'hF0, 8'h90, 8'h80, 8'h01};
		send_text();
		// sequence cut short by the end of the string
		text_q = '{8'hF3, 8'h80, 8'h80};
		send_text();

		sent = 0;
		while (sent < RANDOM_ITEMS) begin
			calm = ($urandom_range(0, 3) == 0);
			quiet = (sent >= QUIET_FROM);
			repeat ($urandom_range(1, 10)) add_char();
			send_text();
		end
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (24) @(posedge clk);

		$display("%0d strings, %0d input bytes, %0d literal bytes checked, %0d U+FFFD",
			strings_done, bytes_in, bytes_out, repl_chars);
		if (errors == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule

>>> sim.f
+incdir+sv
sv/jses_pkg.sv
sv/jses_front.sv
sv/jses_queue.sv
sv/jses_back.sv
sv/json_string_escape_utf8_sanitize_core.sv
sv/jses_checker.sv
tb/json_literal_checker.sv
tb/testbench.sv
